// File: design/gdf_pkg.sv
// shared constants for the direct-sum gravity force block
package gdf_pkg;

  // table size and fixed-point format
  localparam int MAX_PARTICLES = 1024;
  localparam int FRAC_BITS     = 16;

  // derived widths
  localparam int AW        = $clog2(MAX_PARTICLES);
  localparam int CW        = $clog2(MAX_PARTICLES + 1);
  localparam int NUM_SHIFT = 32 - FRAC_BITS;

  // iterative divider: 128-bit dividend, divisor below 2^67
  localparam int DIV_NW = 128;
  localparam int DIV_DW = 67;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  // sequencer step counts
  localparam int SQRT_STEPS = 34;
  localparam int MUL_STEPS  = 33;
  localparam int SQ_STEPS   = 5;
  localparam int SW         = 6;

  // register indexes
  localparam logic REG_COUNT = 1'b0;
  localparam logic REG_COEF  = 1'b1;

  // item function codes
  localparam logic FUNC_STORE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // coefficient after reset is one
  localparam logic [31:0] COEF_RESET = 32'(64'd1 << FRAC_BITS);

endpackage

// File: design/gdf_ram.sv
// generic single-port-write, registered-read ram
module gdf_ram #(
  parameter int W = 32,
  parameter int D = 2
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/gdf_div.sv
// iterative restoring divider, one quotient bit per cycle
module gdf_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [gdf_pkg::DIV_NW-1:0]  num,
  input  logic [gdf_pkg::DIV_DW-1:0]  den,
  output logic [gdf_pkg::DIV_NW-1:0]  quo,
  output logic                        done
);
  import gdf_pkg::*;

  logic [DIV_NW-1:0] q_r;
  logic [DIV_DW:0]   rem_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_CW-1:0] cnt_r;
  logic              done_r;
  logic [DIV_DW:0]   rem_sh;
  logic              ge;

  // shift in the next dividend bit and try a subtract
  assign rem_sh = {rem_r[DIV_DW-1:0], q_r[DIV_NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (start) begin
      cnt_r  <= DIV_CW'(DIV_NW);
      done_r <= 1'b0;
    end else begin
      done_r <= cnt_r == DIV_CW'(1);
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - DIV_CW'(1);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (cnt_r != '0) begin
      rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
      q_r   <= {q_r[DIV_NW-2:0], ge};
    end
  end

  assign quo  = q_r;
  assign done = done_r;

endmodule

// File: design/direct_sum_gravity_force.sv
// Direct-sum gravity force unit: a store item writes one particle slot.
// A query walks slots 0..count-1 (all but itself) one pair at a time through a shared
// sequencer: a read, a load, 5 multiply steps, a check, 34 square-root steps, a divider
// start and a division by r^2 (128 steps and a done), then per axis 33 shift-add steps,
// a divider start and a division by r; coincident pairs skip the root and both divisions.
// The shared restoring divider takes most of the time per pair. Particle data live in one
// ram of MAX_PARTICLES entries of 128 bits; no clearing pass is made after reset.
module direct_sum_gravity_force (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [9:0]         in_index,
  input  logic signed [31:0] in_pos_x,
  input  logic signed [31:0] in_pos_y,
  input  logic signed [31:0] in_pos_z,
  input  logic [31:0]        in_mass,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_force_x,
  output logic signed [63:0] out_force_y,
  output logic signed [63:0] out_force_z,
  output logic               out_coincident,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  import gdf_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_RDI   = 13'b0000000000010,
    S_RDJ   = 13'b0000000000100,
    S_LOADJ = 13'b0000000001000,
    S_SQ    = 13'b0000000010000,
    S_CHK   = 13'b0000000100000,
    S_SQRT  = 13'b0000001000000,
    S_D1GO  = 13'b0000010000000,
    S_DIV1  = 13'b0000100000000,
    S_MUL   = 13'b0001000000000,
    S_D2GO  = 13'b0010000000000,
    S_DIV2  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [10:0]        count_r;
  logic signed [31:0] coef_r;

  // query context
  logic [AW-1:0]             idx_r;
  logic signed [2:0][31:0]   pi_r;
  logic [63:0]               cm_r;
  logic                      cneg_r;
  logic [CW-1:0]             j_r;
  logic [2:0][32:0]          ad_r;
  logic [2:0]                dneg_r;
  logic [31:0]               mj_r;
  logic [66:0]               r2_r;
  logic [95:0]               num_r;
  logic [67:0]               sq_v_r;
  logic [36:0]               sq_rem_r;
  logic [33:0]               root_r;
  logic [95:0]               mag_r;
  logic [127:0]              mcand_r;
  logic [32:0]               mplier_r;
  logic [127:0]              p_r;
  logic [SW-1:0]             step_r;
  logic [1:0]                ax_r;
  logic [2:0][127:0]         acc_r;
  logic                      coin_r;

  // output register
  logic                      out_valid_r;
  logic [2:0][63:0]          out_f_r;
  logic                      out_coin_r;
  logic                      out_sat_r;

  // handshake and ram ports
  logic          in_acc, in_range, out_free;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [127:0]  ram_rdata;
  logic [CW-1:0] cnt_lim;

  assign in_stall = state_r != S_IDLE;
  assign in_acc   = in_valid && !in_stall;
  assign in_range = 32'(in_index) < MAX_PARTICLES;
  assign out_free = !out_valid_r || !out_stall;
  assign ram_we   = in_acc && (in_func == FUNC_STORE) && in_range;
  assign ram_raddr = (state_r == S_IDLE) ? AW'(in_index) : AW'(j_r);
  assign cnt_lim  = (32'(count_r) > MAX_PARTICLES) ? CW'(MAX_PARTICLES) : CW'(count_r);

  gdf_ram #(.W(128), .D(MAX_PARTICLES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_index)),
    .wdata ({in_mass, in_pos_z, in_pos_y, in_pos_x}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // coefficient magnitude and sign
  logic        coef_neg;
  logic [31:0] coef_abs;
  assign coef_neg = coef_r[31];
  assign coef_abs = coef_neg ? 32'(-coef_r) : 32'(coef_r);

  // shared 33x33 multiplier
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  always_comb begin
    mul_a = {1'b0, coef_abs};
    mul_b = {1'b0, ram_rdata[127:96]};
    if (state_r == S_SQ) begin
      case (step_r)
        SW'(0), SW'(1), SW'(2): begin
          mul_a = ad_r[step_r[1:0]];
          mul_b = ad_r[step_r[1:0]];
        end
        SW'(3): begin
          mul_a = {1'b0, cm_r[31:0]};
          mul_b = {1'b0, mj_r};
        end
        default: begin
          mul_a = {1'b0, cm_r[63:32]};
          mul_b = {1'b0, mj_r};
        end
      endcase
    end
  end
  assign mul_p = mul_a * mul_b;

  // position differences of slot j against slot i
  logic signed [2:0][32:0] dj;
  logic [2:0][32:0]        adj;
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dj[k]  = 33'(signed'(ram_rdata[32*k +: 32])) - 33'(signed'(pi_r[k]));
      adj[k] = dj[k][32] ? 33'(-dj[k]) : 33'(dj[k]);
    end
  end

  // square-root step
  logic [36:0] sq_sh, sq_trial;
  logic        sq_ge;
  assign sq_sh    = {sq_rem_r[34:0], sq_v_r[67:66]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // shared divider
  logic                div_start, div_done;
  logic [DIV_NW-1:0]   div_num, div_quo;
  logic [DIV_DW-1:0]   div_den;
  assign div_start = (state_r == S_D1GO) || (state_r == S_D2GO);
  assign div_num   = (state_r == S_D1GO) ? (DIV_NW'(num_r) << NUM_SHIFT) : p_r;
  assign div_den   = (state_r == S_D1GO) ? r2_r : DIV_DW'(root_r);

  gdf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (div_quo),
    .done  (div_done)
  );

  // clamped magnitude and signed term
  logic [95:0]  mag_c;
  logic         term_neg;
  assign mag_c    = (div_quo[127:96] != '0) ? '1 : div_quo[95:0];
  assign term_neg = cneg_r != dneg_r[ax_r];

  // final clamp to the signed 64-bit range
  logic [2:0][63:0] fin_f;
  logic             fin_sat;
  always_comb begin
    fin_sat = 1'b0;
    for (int k = 0; k < 3; k++) begin
      if ((acc_r[k][127:63] == '0) || (acc_r[k][127:63] == '1)) begin
        fin_f[k] = acc_r[k][63:0];
      end else begin
        fin_sat  = 1'b1;
        fin_f[k] = acc_r[k][127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
      end
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_func == FUNC_QUERY) begin
          state_nxt = in_range ? S_RDI : S_DONE;
        end
      end
      S_RDI: state_nxt = S_RDJ;
      S_RDJ: begin
        if (j_r >= cnt_lim) begin
          state_nxt = S_DONE;
        end else if (j_r != CW'(idx_r)) begin
          state_nxt = S_LOADJ;
        end
      end
      S_LOADJ: state_nxt = S_SQ;
      S_SQ: begin
        if (step_r == SW'(SQ_STEPS - 1)) state_nxt = S_CHK;
      end
      S_CHK: state_nxt = (r2_r == '0) ? S_RDJ : S_SQRT;
      S_SQRT: begin
        if (step_r == SW'(SQRT_STEPS - 1)) state_nxt = S_D1GO;
      end
      S_D1GO: state_nxt = S_DIV1;
      S_DIV1: begin
        if (div_done) state_nxt = S_MUL;
      end
      S_MUL: begin
        if (step_r == SW'(MUL_STEPS - 1)) state_nxt = S_D2GO;
      end
      S_D2GO: state_nxt = S_DIV2;
      S_DIV2: begin
        if (div_done) state_nxt = (ax_r == 2'd2) ? S_RDJ : S_MUL;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      coef_r      <= signed'(COEF_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_COUNT: count_r <= cfg_data[10:0];
          REG_COEF:  coef_r  <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        idx_r  <= AW'(in_index);
        j_r    <= '0;
        coin_r <= 1'b0;
        acc_r  <= '0;
        cneg_r <= coef_neg;
      end
      S_RDI: begin
        for (int k = 0; k < 3; k++) pi_r[k] <= signed'(ram_rdata[32*k +: 32]);
        cm_r <= mul_p[63:0];
      end
      S_RDJ: begin
        if (j_r < cnt_lim) j_r <= j_r + CW'(1);
      end
      S_LOADJ: begin
        for (int k = 0; k < 3; k++) begin
          ad_r[k]   <= adj[k];
          dneg_r[k] <= dj[k][32];
        end
        mj_r   <= ram_rdata[127:96];
        r2_r   <= '0;
        step_r <= '0;
      end
      S_SQ: begin
        step_r <= step_r + SW'(1);
        if (step_r < SW'(3)) begin
          r2_r <= r2_r + 67'(mul_p);
        end else if (step_r == SW'(3)) begin
          num_r <= 96'(mul_p[63:0]);
        end else begin
          num_r <= num_r + (96'(mul_p[63:0]) << 32);
        end
      end
      S_CHK: begin
        if (r2_r == '0) coin_r <= 1'b1;
        sq_v_r   <= {1'b0, r2_r};
        sq_rem_r <= '0;
        root_r   <= '0;
        step_r   <= '0;
      end
      S_SQRT: begin
        step_r   <= step_r + SW'(1);
        sq_v_r   <= {sq_v_r[65:0], 2'b00};
        sq_rem_r <= sq_ge ? sq_sh - sq_trial : sq_sh;
        root_r   <= {root_r[32:0], sq_ge};
      end
      S_DIV1: begin
        if (div_done) begin
          mag_r    <= mag_c;
          mcand_r  <= 128'(mag_c);
          mplier_r <= ad_r[0];
          p_r      <= '0;
          ax_r     <= '0;
          step_r   <= '0;
        end
      end
      S_MUL: begin
        step_r   <= step_r + SW'(1);
        if (mplier_r[0]) p_r <= p_r + mcand_r;
        mcand_r  <= {mcand_r[126:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[32:1]};
      end
      S_DIV2: begin
        if (div_done) begin
          acc_r[ax_r] <= term_neg ? acc_r[ax_r] - div_quo : acc_r[ax_r] + div_quo;
          ax_r     <= ax_r + 2'd1;
          mcand_r  <= 128'(mag_r);
          mplier_r <= ad_r[ax_r + 2'd1];
          p_r      <= '0;
          step_r   <= '0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_f_r    <= fin_f;
          out_coin_r <= coin_r;
          out_sat_r  <= fin_sat;
        end
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_force_x    = signed'(out_f_r[0]);
  assign out_force_y    = signed'(out_f_r[1]);
  assign out_force_z    = signed'(out_f_r[2]);
  assign out_coincident = out_coin_r;
  assign out_saturated  = out_sat_r;

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits for it
  a_div_done_owned: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV1 || state_r == S_DIV2))
    else $error("divider done outside a division wait");

  // a new result is only loaded from the done state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result appeared without finishing a query");

  // slot walk never runs past the table
  a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> 32'(j_r) <= MAX_PARTICLES)
    else $error("slot counter beyond table");

  // a pending result is not overwritten while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_f_r))
    else $error("stalled result changed");
`endif

endmodule
